@@ design/ssp_pkg.sv @@
package ssp_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OFFSET_LOS       = 3'd0;
    localparam logic [2:0] CFG_OFFSET_NLOS      = 3'd1;
    localparam logic [2:0] CFG_DIST_FACTOR_LOS  = 3'd2;
    localparam logic [2:0] CFG_DIST_FACTOR_NLOS = 3'd3;
    localparam logic [2:0] CFG_FREQ_FACTOR_LOS  = 3'd4;
    localparam logic [2:0] CFG_FREQ_FACTOR_NLOS = 3'd5;
    localparam logic [2:0] CFG_MIN_LOSS         = 3'd6;

    localparam int OFFSET_W = 17;
    localparam int FACTOR_W = 15;
    localparam int LOSS_W   = 16;
    localparam int FREQ_W   = 20;
    localparam int CFG_W    = 17;

    // log10(2) in Q30.
    localparam logic [28:0] LOG10_2_Q30 = 29'd323228497;

    // Coefficient set chosen by the line-of-sight flag.
    typedef struct packed {
        logic signed [OFFSET_W-1:0] off;
        logic [FACTOR_W-1:0]        df;
        logic [FACTOR_W-1:0]        ff;
    } t_coef;

    // Side data that enters with the coordinates.
    typedef struct packed {
        t_coef             coef;
        logic [FREQ_W-1:0] freq;
    } t_side;

    // Side data that travels alongside the log units.
    typedef struct packed {
        t_coef coef;
        logic  zero;
    } t_tail;

    typedef struct packed {
        logic [LOSS_W-1:0] loss;
        logic              clamped;
        logic              zero;
        logic              sat;
    } t_result;

    // Sixteen fraction bits of log2(1 + idx / 2^tb), found by repeated squaring
    // of a Q30 mantissa with truncation.
    function automatic logic [15:0] log_frac(input int unsigned idx, input int unsigned tb);
        logic [63:0] m;
        logic [15:0] f;
        int          k;
        m = ((64'd1 << tb) | 64'(idx)) << (30 - tb);
        f = '0;
        for (k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            f = {f[14:0], 1'b0};
            if (m >= 64'h0000_0000_8000_0000) begin
                f[0] = 1'b1;
                m = m >> 1;
            end
        end
        return f;
    endfunction

endpackage

@@ design/ssp_ctrl.sv @@
module ssp_ctrl #(
    parameter int NSTG = 11
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    output logic [NSTG-1:0] o_en,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   w_en;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        w_en[NSTG] = !i_out_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_en[k]) begin
                n_vld[k] = (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_en        = w_en[NSTG-1:0];
    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_vld[NSTG-1];

endmodule

@@ design/ssp_dist.sv @@
module ssp_dist #(
    parameter int COORD_BITS = 24
) (
    input  logic                    i_clk,
    input  logic [3:0]              i_en,
    input  logic [COORD_BITS-1:0]   i_base_x,
    input  logic [COORD_BITS-1:0]   i_base_y,
    input  logic [COORD_BITS-1:0]   i_base_z,
    input  logic [COORD_BITS-1:0]   i_mobile_x,
    input  logic [COORD_BITS-1:0]   i_mobile_y,
    input  logic [COORD_BITS-1:0]   i_mobile_z,
    input  ssp_pkg::t_side          i_side,
    output logic [2*COORD_BITS+1:0] o_sum,
    output logic                    o_zero,
    output ssp_pkg::t_side          o_side
);

    localparam int DW  = COORD_BITS + 1;
    localparam int AW  = COORD_BITS;
    localparam int SQW = 2 * COORD_BITS;
    localparam int SW  = 2 * COORD_BITS + 2;

    logic [COORD_BITS-1:0] w_b [3];
    logic [COORD_BITS-1:0] w_m [3];
    logic signed [DW-1:0]  r_dx [3];
    logic [AW-1:0]         r_abs [3];
    logic [SQW-1:0]        r_sq [3];
    logic [SW-1:0]         r_sum;
    logic [SW-1:0]         w_sum;
    logic                  r_zero;
    ssp_pkg::t_side        r_side [4];

    assign w_b[0] = i_base_x;
    assign w_b[1] = i_base_y;
    assign w_b[2] = i_base_z;
    assign w_m[0] = i_mobile_x;
    assign w_m[1] = i_mobile_y;
    assign w_m[2] = i_mobile_z;

    // The difference of two coordinates never reaches the negative limit of
    // DW bits, so its magnitude fits in COORD_BITS.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (i_en[0]) begin
                r_dx[j] <= $signed({w_b[j][COORD_BITS-1], w_b[j]})
                         - $signed({w_m[j][COORD_BITS-1], w_m[j]});
            end
            if (i_en[1]) begin
                r_abs[j] <= r_dx[j][DW-1] ? AW'(-r_dx[j]) : AW'(r_dx[j]);
            end
            if (i_en[2]) begin
                r_sq[j] <= r_abs[j] * r_abs[j];
            end
        end
    end

    assign w_sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_sum  <= w_sum;
            r_zero <= (w_sum == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_side[0] <= i_side;
        end
        for (int k = 1; k < 4; k++) begin
            if (i_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_sum  = r_sum;
    assign o_zero = r_zero;
    assign o_side = r_side[3];

endmodule

@@ design/ssp_log10.sv @@
module ssp_log10 #(
    parameter int W  = 50,
    parameter int TB = 8
) (
    input  logic                       i_clk,
    input  logic [3:0]                 i_en,
    input  logic [W-1:0]               i_val,
    output logic [$clog2(W)+15:0]      o_log
);

    localparam int EW = $clog2(W);
    localparam int OW = EW + 16;
    localparam int PW = OW + 29;
    localparam int TS = 1 << TB;

    logic [15:0]      w_tab [TS];
    logic [EW-1:0]    w_e;
    logic [EW-1:0]    r_e;
    logic [W-1:0]     r_v;
    logic [EW-1:0]    w_sh;
    logic [W+TB-2:0]  w_ext;
    logic [TB-1:0]    w_idx;
    logic [OW-1:0]    r_l2;
    logic [PW-1:0]    r_prod;
    logic [PW:0]      w_rnd;
    logic [OW-1:0]    r_log;

    for (genvar g = 0; g < TS; g++) begin : g_tab
        localparam logic [15:0] FRAC = ssp_pkg::log_frac(g, TB);
        assign w_tab[g] = FRAC;
    end

    // Leading-one position, which is the integer part of log2.
    always_comb begin
        w_e = '0;
        for (int i = 0; i < W; i++) begin
            if (i_val[i]) begin
                w_e = EW'(i);
            end
        end
    end

    // The bits just below the leading one index the fraction table.
    assign w_sh  = EW'(W - 1) - r_e;
    assign w_ext = {r_v[W-2:0], {TB{1'b0}}} << w_sh;
    assign w_idx = w_ext[W+TB-2 -: TB];
    assign w_rnd = (PW+1)'(r_prod) + (PW+1)'(1 << 29);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_e <= w_e;
            r_v <= i_val;
        end
        if (i_en[1]) begin
            r_l2 <= {r_e, 16'd0} + OW'(w_tab[w_idx]);
        end
        if (i_en[2]) begin
            r_prod <= PW'(r_l2) * PW'(ssp_pkg::LOG10_2_Q30);
        end
        if (i_en[3]) begin
            r_log <= w_rnd[30 +: OW];
        end
    end

    assign o_log = r_log;

endmodule

@@ design/ssp_combine.sv @@
module ssp_combine #(
    parameter int DOW = 22,
    parameter int FOW = 21
) (
    input  logic                  i_clk,
    input  logic [2:0]            i_en,
    input  logic [DOW-1:0]        i_log_dist,
    input  logic [FOW-1:0]        i_log_freq,
    input  ssp_pkg::t_tail        i_tail,
    input  logic [ssp_pkg::LOSS_W-1:0] i_min_loss,
    output ssp_pkg::t_result      o_result
);

    localparam int PDW = DOW + 17;
    localparam int PFW = FOW + 17;
    localparam int MW  = (PDW > PFW + 1) ? PDW : PFW + 1;
    localparam int TW  = ((MW > 34) ? MW : 34) + 2;
    localparam int RW  = TW - 17;

    logic signed [DOW:0]   w_lgd;
    logic signed [FOW:0]   w_lgf;
    logic signed [PDW-1:0] w_pd;
    logic signed [PFW-1:0] w_pf;
    logic signed [PDW-1:0] r_pd;
    logic signed [PFW-1:0] r_pf;
    logic signed [ssp_pkg::OFFSET_W-1:0] r_off;
    logic                  r_zero0;
    logic signed [TW-1:0]  w_total;
    logic signed [RW-1:0]  r_rnd;
    logic                  r_zero1;
    logic                  w_lt;
    logic                  w_gt;
    ssp_pkg::t_result      r_res;
    ssp_pkg::t_result      n_res;

    // log10 of the distance in meters is half the log of the squared
    // distance in centimeters minus two; both logs drop the unit offset here.
    assign w_lgd = $signed({1'b0, i_log_dist}) - $signed((DOW+1)'(262144));
    assign w_lgf = $signed({1'b0, i_log_freq}) - $signed((FOW+1)'(65536));
    assign w_pd  = $signed({1'b0, i_tail.coef.df}) * w_lgd;
    assign w_pf  = $signed({1'b0, i_tail.coef.ff}) * w_lgf;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pd    <= w_pd;
            r_pf    <= w_pf;
            r_off   <= i_tail.coef.off;
            r_zero0 <= i_tail.zero;
        end
    end

    // Sum at Q25 dB and round half up to Q8.
    assign w_total = (TW'(r_off) <<< 17) + TW'(r_pd) + (TW'(r_pf) <<< 1) + TW'(65536);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rnd   <= w_total[TW-1:17];
            r_zero1 <= r_zero0;
        end
    end

    assign w_lt = r_rnd < $signed({1'b0, i_min_loss});
    assign w_gt = r_rnd > 18'sd65535;

    always_comb begin
        n_res = '0;
        if (r_zero1) begin
            n_res.loss    = i_min_loss;
            n_res.clamped = 1'b1;
            n_res.zero    = 1'b1;
        end else if (w_lt) begin
            n_res.loss    = i_min_loss;
            n_res.clamped = 1'b1;
        end else if (w_gt) begin
            n_res.loss    = '1;
            n_res.sat     = 1'b1;
        end else begin
            n_res.loss    = r_rnd[ssp_pkg::LOSS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

@@ design/single_slope_path_loss_unit.sv @@
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     positions, line_of_sight, freq_tenth_mhz
// result    out        o_out_valid / i_out_stall   loss_q8, clamped, zero_distance, saturated
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item enters per cycle while the output is not stalled; the result
// passes through eleven register stages (four for the squared
// distance, four for each log unit, three to combine, round and clamp).
// Reset is synchronous and active low; it clears the stage valid bits and
// loads the default coefficients.
// A stalled result holds its stage; earlier stages keep filling any empty
// stage, so input is refused only when every stage holds an item.
module single_slope_path_loss_unit #(
    parameter int COORD_BITS     = 24,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_base_x,
    input  logic [COORD_BITS-1:0] i_base_y,
    input  logic [COORD_BITS-1:0] i_base_z,
    input  logic [COORD_BITS-1:0] i_mobile_x,
    input  logic [COORD_BITS-1:0] i_mobile_y,
    input  logic [COORD_BITS-1:0] i_mobile_z,
    input  logic                  i_line_of_sight,
    input  logic [ssp_pkg::FREQ_W-1:0] i_freq_tenth_mhz,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ssp_pkg::LOSS_W-1:0] o_loss_q8,
    output logic                  o_clamped,
    output logic                  o_zero_distance,
    output logic                  o_saturated,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [ssp_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int NSTG = 11;
    localparam int SW   = 2 * COORD_BITS + 2;
    localparam int DOW  = $clog2(SW) + 16;
    localparam int FOW  = $clog2(ssp_pkg::FREQ_W) + 16;

    // Configuration registers. The user must change them only while the block
    // is idle (the block does not enforce this), so later stages may read them directly.
    logic signed [ssp_pkg::OFFSET_W-1:0] r_offset_los;
    logic signed [ssp_pkg::OFFSET_W-1:0] r_offset_nlos;
    logic [ssp_pkg::FACTOR_W-1:0]        r_dist_factor_los;
    logic [ssp_pkg::FACTOR_W-1:0]        r_dist_factor_nlos;
    logic [ssp_pkg::FACTOR_W-1:0]        r_freq_factor_los;
    logic [ssp_pkg::FACTOR_W-1:0]        r_freq_factor_nlos;
    logic [ssp_pkg::LOSS_W-1:0]          r_min_loss;

    logic [NSTG-1:0]      w_en;
    ssp_pkg::t_side       w_side_in;
    ssp_pkg::t_side       w_side_s3;
    logic [SW-1:0]        w_sum;
    logic                 w_zero;
    logic [DOW-1:0]       w_log_dist;
    logic [FOW-1:0]       w_log_freq;
    ssp_pkg::t_tail       r_tail [4];
    ssp_pkg::t_result     w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_los       <= '0;
            r_offset_nlos      <= '0;
            r_dist_factor_los  <= 15'd5120;
            r_dist_factor_nlos <= 15'd10240;
            r_freq_factor_los  <= 15'd5120;
            r_freq_factor_nlos <= 15'd5120;
            r_min_loss         <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssp_pkg::CFG_OFFSET_LOS: begin
                    r_offset_los <= i_cfg_data;
                end
                ssp_pkg::CFG_OFFSET_NLOS: begin
                    r_offset_nlos <= i_cfg_data;
                end
                ssp_pkg::CFG_DIST_FACTOR_LOS: begin
                    r_dist_factor_los <= i_cfg_data[ssp_pkg::FACTOR_W-1:0];
                end
                ssp_pkg::CFG_DIST_FACTOR_NLOS: begin
                    r_dist_factor_nlos <= i_cfg_data[ssp_pkg::FACTOR_W-1:0];
                end
                ssp_pkg::CFG_FREQ_FACTOR_LOS: begin
                    r_freq_factor_los <= i_cfg_data[ssp_pkg::FACTOR_W-1:0];
                end
                ssp_pkg::CFG_FREQ_FACTOR_NLOS: begin
                    r_freq_factor_nlos <= i_cfg_data[ssp_pkg::FACTOR_W-1:0];
                end
                ssp_pkg::CFG_MIN_LOSS: begin
                    r_min_loss <= i_cfg_data[ssp_pkg::LOSS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage valid bits and per-stage load enables.
    ssp_ctrl #(
        .NSTG(NSTG)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_stall(i_out_stall),
        .o_en       (w_en),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid)
    );

    // The coefficient set is picked as the item enters; a zero frequency
    // code counts as one.
    always_comb begin
        w_side_in.coef.off = i_line_of_sight ? r_offset_los : r_offset_nlos;
        w_side_in.coef.df  = i_line_of_sight ? r_dist_factor_los : r_dist_factor_nlos;
        w_side_in.coef.ff  = i_line_of_sight ? r_freq_factor_los : r_freq_factor_nlos;
        w_side_in.freq     = (i_freq_tenth_mhz == '0) ? ssp_pkg::FREQ_W'(1) : i_freq_tenth_mhz;
    end

    // Stages 0 to 3: coordinate differences, magnitudes, squares and their sum.
    ssp_dist #(
        .COORD_BITS(COORD_BITS)
    ) u_dist (
        .i_clk     (i_clk),
        .i_en      (w_en[3:0]),
        .i_base_x  (i_base_x),
        .i_base_y  (i_base_y),
        .i_base_z  (i_base_z),
        .i_mobile_x(i_mobile_x),
        .i_mobile_y(i_mobile_y),
        .i_mobile_z(i_mobile_z),
        .i_side    (w_side_in),
        .o_sum     (w_sum),
        .o_zero    (w_zero),
        .o_side    (w_side_s3)
    );

    // Stages 4 to 7: both logarithms side by side.
    ssp_log10 #(
        .W (SW),
        .TB(LOG_TABLE_BITS)
    ) u_log_dist (
        .i_clk(i_clk),
        .i_en (w_en[7:4]),
        .i_val(w_sum),
        .o_log(w_log_dist)
    );

    ssp_log10 #(
        .W (ssp_pkg::FREQ_W),
        .TB(LOG_TABLE_BITS)
    ) u_log_freq (
        .i_clk(i_clk),
        .i_en (w_en[7:4]),
        .i_val(w_side_s3.freq),
        .o_log(w_log_freq)
    );

    // Coefficients and the zero-distance flag ride along with the log units.
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_tail[0].coef <= w_side_s3.coef;
            r_tail[0].zero <= w_zero;
        end
        for (int k = 1; k < 4; k++) begin
            if (w_en[4+k]) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    // Stages 8 to 10: products, sum and rounding, then clamp and saturation.
    ssp_combine #(
        .DOW(DOW),
        .FOW(FOW)
    ) u_combine (
        .i_clk     (i_clk),
        .i_en      (w_en[10:8]),
        .i_log_dist(w_log_dist),
        .i_log_freq(w_log_freq),
        .i_tail    (r_tail[3]),
        .i_min_loss(r_min_loss),
        .o_result  (w_result)
    );

    assign o_loss_q8       = w_result.loss;
    assign o_clamped       = w_result.clamped;
    assign o_zero_distance = w_result.zero;
    assign o_saturated     = w_result.sat;

endmodule

@@ design/ssp_checker.sv @@
module ssp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_loss_q8,
    input logic        o_clamped,
    input logic        o_zero_distance,
    input logic        o_saturated
);

    // A coinciding pair of positions is always flagged clamped, never saturated.
    a_zero_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_distance |-> o_clamped && !o_saturated)
        else $error("zero distance without clamp");

    // Clamping and saturation exclude each other.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_clamped && o_saturated))
        else $error("clamped and saturated together");

    // A saturated result sits at the top of the range.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> o_loss_q8 == 16'hFFFF)
        else $error("saturated result below the top");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

    // A stalled result stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_loss_q8))
        else $error("stalled result changed");

endmodule

bind single_slope_path_loss_unit ssp_checker u_ssp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_loss_q8      (o_loss_q8),
    .o_clamped      (o_clamped),
    .o_zero_distance(o_zero_distance),
    .o_saturated    (o_saturated)
);
